### hw/rtl/wildcard_glob_matcher_top_macros.svh
// Assertion macros for the wildcard matcher.
// Used by the top level only; no other dependencies.
`ifndef WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH
`define WILDCARD_GLOB_MATCHER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WGM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/wgm_pkg.sv
// Shared types, codes and helpers for the wildcard matcher.
// No dependencies.
package wgm_pkg;

  localparam int PATTERN_MAX_DEF = 64;
  localparam int VALUE_MAX_DEF   = 32768;

  localparam logic [1:0] REQ_PATTERN = 2'd0;
  localparam logic [1:0] REQ_VALUE   = 2'd1;
  localparam logic [1:0] REQ_END     = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PAT_LONG = 2'd1;
  localparam logic [1:0] ST_VAL_LONG = 2'd2;

  localparam logic [15:0] CH_STAR     = 16'h002A;
  localparam logic [15:0] CH_QUESTION = 16'h003F;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch the incoming beat
    logic close;    // register the star closure
    logic apply;    // commit the update / emit the result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_close;  // incoming beat reads the closure
  } dp_status_t;

  // ASCII-only case folding
  function automatic logic [15:0] fold_case(input logic [15:0] c);
    if (c >= 16'h0041 && c <= 16'h005A) begin
      return c + 16'h0020;
    end
    return c;
  endfunction

endpackage

### hw/rtl/wildcard_glob_matcher_top.sv
// Case-insensitive '*'/'?' wildcard matcher, top level.
// Beats do not overlap: a pattern beat (or an unused code) runs capture and apply,
//   a value or end beat capture, closure register and apply, with busy held meanwhile.
// The result strobe is registered at the apply step of the end beat; the
//   receiver cannot stall, so out_valid is high for exactly one cycle.
// Reset (synchronous, rst_n low): empty pattern, match vector at its initial column.
//
// The pattern is held in per-position registers, one compare cell each. Every value
// character first registers the star closure of the match vector (a log-depth prefix
// scan), then all cells update in parallel from it. An end beat reads the closure at
// the pattern length and reports it with a status; overflow of either the pattern or
// the value forces a miss, pattern overflow taking precedence.
`include "wildcard_glob_matcher_top_macros.svh"

module wildcard_glob_matcher_top #(
  parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF,
  parameter int VALUE_MAX   = wgm_pkg::VALUE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beat: accepted when start && !busy
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_char_code,
  input  logic        in_pattern_first,
  // result beat: one-cycle strobe
  output logic        out_valid,
  output logic        out_matched,
  output logic [1:0]  out_status
);

  wgm_pkg::cmd_t       cmd;
  wgm_pkg::dp_status_t st;

  // sequencer
  wgm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  // storage, cells and result registers
  wgm_datapath #(
    .PATTERN_MAX (PATTERN_MAX),
    .VALUE_MAX   (VALUE_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_req_type      (in_req_type),
    .in_char_code     (in_char_code),
    .in_pattern_first (in_pattern_first),
    .out_valid        (out_valid),
    .out_matched      (out_matched),
    .out_status       (out_status)
  );

  // result only shows once the sequencer is back in idle
  `WGM_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid, !busy, "result while busy")
  // an accepted beat always occupies the sequencer
  `WGM_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept without busy")
  // the strobe is never held high
  `WGM_ASSERT_NEXT(a_strobe_once, clk, rst_n, out_valid, !out_valid, "strobe held")
  // any overflow status carries a miss
  `WGM_ASSERT_NOW(a_ovf_miss, clk, rst_n, out_valid && out_status != wgm_pkg::ST_OK,
                  !out_matched, "match with overflow status")

endmodule

### hw/rtl/wgm_closure.sv
// Star closure of the match vector as a parallel prefix scan.
// Depends on nothing but its parameter.
module wgm_closure #(
  parameter int N = 64
) (
  input  logic [N:0]   mv,
  input  logic [N-1:0] star,
  output logic [N:0]   eff
);

  localparam int NP = N + 1;
  localparam int LV = $clog2(NP);

  logic [NP-1:0] g [0:LV];
  logic [NP-1:0] p [0:LV];

  // eff[j] = mv[j] | (star[j-1] & eff[j-1]), solved in log levels
  always_comb begin
    g[0] = mv;
    p[0] = {star, 1'b0};
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j < NP; j++) begin
        if (j >= (1 << l)) begin
          g[l+1][j] = g[l][j] | (p[l][j] & g[l][j-(1<<l)]);
          p[l+1][j] = p[l][j] & p[l][j-(1<<l)];
        end else begin
          g[l+1][j] = g[l][j];
          p[l+1][j] = p[l][j];
        end
      end
    end
  end

  assign eff = g[LV];

endmodule

### hw/rtl/wgm_ctrl.sv
// Sequencer for the wildcard matcher: idle, closure and apply steps.
// Depends on wgm_pkg.
module wgm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  wgm_pkg::dp_status_t st,
  output logic                busy,
  output wgm_pkg::cmd_t       cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLOSE = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = st.needs_close ? S_CLOSE : S_APPLY;
        end
      end
      S_CLOSE: state_nxt = S_APPLY;
      S_APPLY: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign cmd.capture = start && (state_r == S_IDLE);
  assign cmd.close   = (state_r == S_CLOSE);
  assign cmd.apply   = (state_r == S_APPLY);

endmodule

### hw/rtl/wgm_datapath.sv
// Pattern store, match vector, counters and result registers.
// Depends on wgm_pkg and wgm_closure.
module wgm_datapath #(
  parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEF,
  parameter int VALUE_MAX   = wgm_pkg::VALUE_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wgm_pkg::cmd_t       cmd,
  output wgm_pkg::dp_status_t st,
  input  logic [1:0]          in_req_type,
  input  logic [15:0]         in_char_code,
  input  logic                in_pattern_first,
  output logic                out_valid,
  output logic                out_matched,
  output logic [1:0]          out_status
);

  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int VCNT_W = $clog2(VALUE_MAX + 1);
  localparam logic [PATTERN_MAX:0] MV_INIT = (PATTERN_MAX + 1)'(1);

  // latched beat
  logic [1:0]  req_r;
  logic [15:0] chr_r;
  logic        first_r;

  logic [15:0]          pstore_r [PATTERN_MAX];
  logic [LEN_W-1:0]     plen_r, plen_nxt;
  logic                 povf_r, povf_nxt;
  logic [PATTERN_MAX:0] mv_r, mv_nxt;
  logic [VCNT_W-1:0]    vcnt_r, vcnt_nxt;
  logic                 vovf_r, vovf_nxt;
  logic [PATTERN_MAX:0] eff_r, eff_w;
  logic                 oval_r, oval_nxt;
  logic                 omat_r, omat_nxt;
  logic [1:0]           ost_r, ost_nxt;

  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX:0]   mv_upd;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [LEN_W-1:0]       base_len;
  logic [PATTERN_MAX:0]   base_mv;

  assign st.needs_close = (in_req_type == wgm_pkg::REQ_VALUE) ||
                          (in_req_type == wgm_pkg::REQ_END);

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      star[i] = (pstore_r[i] == wgm_pkg::CH_STAR);
    end
  end

  wgm_closure #(.N(PATTERN_MAX)) u_closure (
    .mv   (mv_r),
    .star (star),
    .eff  (eff_w)
  );

  // one cell per pattern position
  always_comb begin
    mv_upd[0] = 1'b0;
    for (int j = 1; j <= PATTERN_MAX; j++) begin
      if (j <= int'(plen_r)) begin
        if (pstore_r[j-1] == wgm_pkg::CH_STAR) begin
          mv_upd[j] = eff_r[j];
        end else if (pstore_r[j-1] == wgm_pkg::CH_QUESTION || pstore_r[j-1] == chr_r) begin
          mv_upd[j] = eff_r[j-1];
        end else begin
          mv_upd[j] = 1'b0;
        end
      end else begin
        mv_upd[j] = mv_r[j];
      end
    end
  end

  always_comb begin
    plen_nxt = plen_r;
    povf_nxt = povf_r;
    mv_nxt   = mv_r;
    vcnt_nxt = vcnt_r;
    vovf_nxt = vovf_r;
    wr_en    = 1'b0;
    wr_idx   = '0;
    oval_nxt = 1'b0;
    omat_nxt = omat_r;
    ost_nxt  = ost_r;
    base_len = first_r ? '0 : plen_r;
    base_mv  = first_r ? MV_INIT : mv_r;
    if (cmd.apply) begin
      unique case (req_r)
        wgm_pkg::REQ_PATTERN: begin
          if (first_r) begin
            povf_nxt = 1'b0;
            vcnt_nxt = '0;
            vovf_nxt = 1'b0;
          end
          mv_nxt = base_mv;
          if (int'(base_len) < PATTERN_MAX) begin
            wr_en  = 1'b1;
            wr_idx = base_len[IDX_W-1:0];
            for (int j = 1; j <= PATTERN_MAX; j++) begin
              if (j == int'(base_len) + 1) begin
                mv_nxt[j] = 1'b0;
              end
            end
            plen_nxt = base_len + 1'b1;
          end else begin
            plen_nxt = base_len;
            povf_nxt = 1'b1;
          end
        end
        wgm_pkg::REQ_VALUE: begin
          if (int'(vcnt_r) >= VALUE_MAX) begin
            vovf_nxt = 1'b1;
          end else begin
            vcnt_nxt = vcnt_r + 1'b1;
            mv_nxt   = mv_upd;
          end
        end
        wgm_pkg::REQ_END: begin
          oval_nxt = 1'b1;
          if (povf_r) begin
            omat_nxt = 1'b0;
            ost_nxt  = wgm_pkg::ST_PAT_LONG;
          end else if (vovf_r) begin
            omat_nxt = 1'b0;
            ost_nxt  = wgm_pkg::ST_VAL_LONG;
          end else begin
            omat_nxt = eff_r[plen_r];
            ost_nxt  = wgm_pkg::ST_OK;
          end
          mv_nxt   = MV_INIT;
          vcnt_nxt = '0;
          vovf_nxt = 1'b0;
        end
        default: ;  // unused request code
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
      povf_r <= 1'b0;
      mv_r   <= MV_INIT;
      vcnt_r <= '0;
      vovf_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      plen_r <= plen_nxt;
      povf_r <= povf_nxt;
      mv_r   <= mv_nxt;
      vcnt_r <= vcnt_nxt;
      vovf_r <= vovf_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_req_type;
      chr_r   <= wgm_pkg::fold_case(in_char_code);
      first_r <= in_pattern_first;
    end
    if (cmd.close) begin
      eff_r <= eff_w;
    end
    if (wr_en) begin
      pstore_r[wr_idx] <= chr_r;
    end
    omat_r <= omat_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_valid   = oval_r;
  assign out_matched = omat_r;
  assign out_status  = ost_r;

endmodule

### tb/wgm_tb_pkg.sv
// Expected-result tracking for the wildcard glob matcher testbench.
// Depends on wgm_pkg for request/status codes, wildcard characters and sizes.
package wgm_tb_pkg;
  import wgm_pkg::*;

  typedef struct packed {
    logic       matched;
    logic [1:0] status;
  } glob_verdict_t;

  // Tracks pattern and match columns beat by beat and queues the verdict
  // each end-of-value beat should produce.
  class glob_match_tracker;
    logic [15:0]            pat_chars [PATTERN_MAX_DEF];
    int unsigned            pat_len;
    bit                     pat_ovf;
    bit [PATTERN_MAX_DEF:0] live_cols;   // match columns before star closure
    int unsigned            text_len;
    bit                     text_ovf;
    glob_verdict_t          verdicts_due [$];
    int unsigned            mismatches;

    function new();
      pat_len    = 0;
      pat_ovf    = 1'b0;
      live_cols  = fresh_cols();
      text_len   = 0;
      text_ovf   = 1'b0;
      mismatches = 0;
    endfunction

    function bit [PATTERN_MAX_DEF:0] fresh_cols();
      bit [PATTERN_MAX_DEF:0] cols;
      cols    = '0;
      cols[0] = 1'b1;
      return cols;
    endfunction

    function logic [15:0] lower_ascii(logic [15:0] code);
      if (code >= 16'h0041 && code <= 16'h005A) begin
        return code + 16'h0020;
      end
      return code;
    endfunction

    // a '*' passes its left neighbor's bit through
    function bit [PATTERN_MAX_DEF:0] closed_cols();
      bit [PATTERN_MAX_DEF:0] eff;
      eff    = '0;
      eff[0] = live_cols[0];
      for (int j = 1; j <= pat_len; j++) begin
        eff[j] = live_cols[j] | ((pat_chars[j-1] == CH_STAR) & eff[j-1]);
      end
      return eff;
    endfunction

    function void take_beat(logic [1:0] req, logic [15:0] code, logic first);
      logic [15:0]            c;
      bit [PATTERN_MAX_DEF:0] eff;
      glob_verdict_t          v;
      c = lower_ascii(code);
      case (req)
        REQ_PATTERN: begin
          if (first) begin
            pat_len   = 0;
            pat_ovf   = 1'b0;
            live_cols = fresh_cols();
            text_len  = 0;
            text_ovf  = 1'b0;
          end
          if (pat_len < PATTERN_MAX_DEF) begin
            pat_chars[pat_len]    = c;
            live_cols[pat_len+1]  = 1'b0;
            pat_len++;
          end else begin
            pat_ovf = 1'b1;
          end
        end
        REQ_VALUE: begin
          if (text_len >= VALUE_MAX_DEF) begin
            text_ovf = 1'b1;
          end else begin
            text_len++;
            eff          = closed_cols();
            live_cols[0] = 1'b0;
            for (int j = 1; j <= pat_len; j++) begin
              if (pat_chars[j-1] == CH_STAR) begin
                live_cols[j] = eff[j];
              end else if (pat_chars[j-1] == CH_QUESTION || pat_chars[j-1] == c) begin
                live_cols[j] = eff[j-1];
              end else begin
                live_cols[j] = 1'b0;
              end
            end
          end
        end
        REQ_END: begin
          eff       = closed_cols();
          v.status  = pat_ovf ? ST_PAT_LONG : (text_ovf ? ST_VAL_LONG : ST_OK);
          v.matched = (v.status == ST_OK) & eff[pat_len];
          verdicts_due = {verdicts_due, v};
          live_cols = fresh_cols();
          text_len  = 0;
          text_ovf  = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(logic matched, logic [1:0] status);
      glob_verdict_t v;
      if (verdicts_due.size() == 0) begin
        $error("unexpected result beat: matched=%0b status=%0d", matched, status);
        mismatches++;
        return;
      end
      v = verdicts_due.pop_front();
      if (matched !== v.matched) begin
        $error("matched: expected %0b, got %0b", v.matched, matched);
        mismatches++;
      end
      if (status !== v.status) begin
        $error("status: expected %0d, got %0d", v.status, status);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

endpackage

### tb/tb_wildcard_glob_matcher_top.sv
// Self-checking testbench for wildcard_glob_matcher_top: directed and random beats,
// results checked against glob_match_tracker. Depends on wgm_pkg and wgm_tb_pkg.
module tb_wildcard_glob_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wgm_pkg::*;
  import wgm_tb_pkg::*;

  localparam logic [1:0] REQ_UNUSED   = 2'd3;
  localparam int         RANDOM_BEATS = 1300;
  // fold-range neighbors plus the wildcards used as plain value characters
  localparam logic [15:0] ODD_CHARS [6] = '{16'h0040, 16'h005B, 16'h0060, 16'h007B,
                                            CH_STAR, CH_QUESTION};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_req_type;
  logic [15:0] in_char_code;
  logic        in_pattern_first;
  logic        out_valid;
  logic        out_matched;
  logic [1:0]  out_status;

  glob_match_tracker verdicts;
  bit                sender_idle;     // random gaps between beats when set
  int unsigned       counted_beats;   // accepted beats, ignored codes excluded
  logic [15:0]       cur_pattern [$]; // pattern as sent, for building hit values
  logic [15:0]       cur_text [$];

  wildcard_glob_matcher_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_char_code     (in_char_code),
    .in_pattern_first (in_pattern_first),
    .out_valid        (out_valid),
    .out_matched      (out_matched),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  // Result beats cannot be stalled: every strobe seen at an edge is checked.
  // Values read here are the ones held just before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      verdicts.check_verdict(out_matched, out_status);
    end
  end

  // Hard stop in case a beat is never accepted or a result never shows up.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Drive one beat and wait until the block takes it (start && !busy at an edge).
  // start is left high afterwards; a drain, or a next call that leaves a gap, lowers it.
  task automatic send_beat(input logic [1:0] req, input logic [15:0] code,
                           input logic first);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_req_type      <= req;
    in_char_code     <= code;
    in_pattern_first <= first;
    do @(posedge clk); while (busy);
    verdicts.take_beat(req, code, first);
    if (req != REQ_UNUSED) begin
      counted_beats++;
    end
  endtask

  // Sender holds off until every queued verdict has come back.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (verdicts.pending() != 0);
  endtask

  // Mostly a-c in either case, sometimes fold-range neighbors, wildcards or any code unit.
  function automatic logic [15:0] rand_text_char();
    logic [15:0] c;
    case ($urandom_range(0, 9))
      8: c = 16'($urandom);
      9: c = ODD_CHARS[$urandom_range(0, 5)];
      default: begin
        c = 16'h0041 + 16'($urandom_range(0, 2));
        if ($urandom_range(0, 1) != 0) begin
          c = c | 16'h0020;
        end
      end
    endcase
    return c;
  endfunction

  function automatic logic [15:0] rand_glob_char();
    case ($urandom_range(0, 9))
      0, 1:    return CH_STAR;
      2:       return CH_QUESTION;
      default: return rand_text_char();
    endcase
  endfunction

  initial begin
    int unsigned pick;
    int unsigned plen;
    logic [15:0] c;

    verdicts         = new();
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_req_type      <= REQ_PATTERN;
    in_char_code     <= 16'h0000;
    in_pattern_first <= 1'b0;
    sender_idle      = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    // empty pattern straight out of reset matches the empty value
    send_beat(REQ_END, 16'hFFFF, 1'b0);
    // "A?*" vs "aZ": folding, single wildcard, star over nothing;
    // the unused code with the restart flag set must not restart anything
    send_beat(REQ_PATTERN, 16'h0041, 1'b1);
    send_beat(REQ_PATTERN, CH_QUESTION, 1'b0);
    send_beat(REQ_PATTERN, CH_STAR, 1'b0);
    send_beat(REQ_UNUSED, 16'hFFFF, 1'b1);
    send_beat(REQ_VALUE, 16'h0061, 1'b0);
    send_beat(REQ_VALUE, 16'h005A, 1'b0);
    send_beat(REQ_END, 16'h0000, 1'b0);
    // edges of the fold range and of the code space, exact match
    send_beat(REQ_PATTERN, 16'h0040, 1'b1);
    send_beat(REQ_PATTERN, 16'h005A, 1'b0);
    send_beat(REQ_PATTERN, 16'h005B, 1'b0);
    send_beat(REQ_PATTERN, 16'hFFFF, 1'b0);
    send_beat(REQ_PATTERN, 16'h0000, 1'b0);
    send_beat(REQ_VALUE, 16'h0040, 1'b0);
    send_beat(REQ_VALUE, 16'h007A, 1'b0);
    send_beat(REQ_VALUE, 16'h005B, 1'b0);
    send_beat(REQ_VALUE, 16'hFFFF, 1'b0);
    send_beat(REQ_VALUE, 16'h0000, 1'b0);
    send_beat(REQ_END, 16'h0000, 1'b0);
    // same pattern, empty value: miss
    send_beat(REQ_END, 16'h0000, 1'b0);
    // pattern grown after value chars: "a" then "*" appended mid-value
    send_beat(REQ_PATTERN, 16'h0061, 1'b1);
    send_beat(REQ_VALUE, 16'h0041, 1'b0);
    send_beat(REQ_PATTERN, CH_STAR, 1'b0);
    send_beat(REQ_VALUE, 16'h0078, 1'b0);
    send_beat(REQ_END, 16'h0000, 1'b0);
    hold_until_drained();

    // ---- random ----
    // Mostly a fresh pattern followed by values built to hit it, some of them
    // spoiled; noise beats (ignored codes, appends, restarts) sprinkled in.
    counted_beats = 0;
    while (counted_beats < RANDOM_BEATS) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      if (cur_pattern.size() == 0 || $urandom_range(0, 9) != 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 16) begin
          plen = $urandom_range(1, 8);
        end else if (pick < 19) begin
          plen = $urandom_range(9, PATTERN_MAX_DEF);
        end else begin
          plen = $urandom_range(PATTERN_MAX_DEF + 1, PATTERN_MAX_DEF + 8);
        end
        cur_pattern.delete();
        repeat (plen) cur_pattern = {cur_pattern, rand_glob_char()};
        foreach (cur_pattern[i]) begin
          send_beat(REQ_PATTERN, cur_pattern[i], i == 0);
        end
      end
      repeat ($urandom_range(1, 4)) begin
        cur_text.delete();
        if ($urandom_range(0, 9) < 7) begin
          foreach (cur_pattern[i]) begin
            c = cur_pattern[i];
            if (c == CH_STAR) begin
              repeat ($urandom_range(0, 3)) cur_text = {cur_text, rand_text_char()};
            end else if (c == CH_QUESTION) begin
              cur_text = {cur_text, rand_text_char()};
            end else begin
              // same letter, either case
              if ((c | 16'h0020) >= 16'h0061 && (c | 16'h0020) <= 16'h007A &&
                  $urandom_range(0, 1) != 0) begin
                c = c ^ 16'h0020;
              end
              cur_text = {cur_text, c};
            end
          end
          if (cur_text.size() != 0 && $urandom_range(0, 3) == 0) begin
            cur_text[$urandom_range(0, cur_text.size() - 1)] = rand_text_char();
          end
        end else begin
          repeat ($urandom_range(0, 10)) cur_text = {cur_text, rand_text_char()};
        end
        foreach (cur_text[i]) begin
          case ($urandom_range(0, 39))
            0: send_beat(REQ_UNUSED, 16'($urandom), 1'($urandom));
            1: begin
              c = rand_glob_char();
              cur_pattern = {cur_pattern, c};
              send_beat(REQ_PATTERN, c, 1'b0);
            end
            2: begin
              // broken sequence: restart in the middle of a value
              c = rand_glob_char();
              cur_pattern.delete();
              cur_pattern = {cur_pattern, c};
              send_beat(REQ_PATTERN, c, 1'b1);
            end
            default: ;
          endcase
          // restart flag means nothing on value beats
          send_beat(REQ_VALUE, cur_text[i], 1'($urandom));
        end
        send_beat(REQ_END, 16'($urandom), 1'($urandom));
        if ($urandom_range(0, 7) == 0) begin
          hold_until_drained();
        end
      end
    end

    // ---- wind down ----
    start <= 1'b0;
    while (verdicts.pending() != 0) @(posedge clk);
    // room for a stray strobe after the last expected one
    repeat (8) @(posedge clk);
    if (verdicts.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
